/* hw/rtl/krtu_pkg.sv */
// ----------------------------------------------------------------------------
// krtu_pkg
// Types and codes shared by the keyed record table: commands, status codes,
// controller states and the layout of one stored entry.
// ----------------------------------------------------------------------------
package krtu_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_UPSERT = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_NOT_FOUND = 3'd0,
        STAT_FOUND     = 3'd1,
        STAT_DELETED   = 3'd2,
        STAT_CREATED   = 3'd3,
        STAT_UPDATED   = 3'd4,
        STAT_FULL      = 3'd5,
        STAT_IGNORED   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_IDLE   = 2'd1,
        S_SCAN   = 2'd2,
        S_FINISH = 2'd3
    } t_state;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] team;
        logic [31:0] league;
        logic [7:0]  kind;
        logic [31:0] first_date;
        logic [31:0] last_date;
    } t_record;

    typedef struct packed {
        logic    valid;
        t_record rec;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* hw/rtl/keyed_record_table_upsert.sv */
// ----------------------------------------------------------------------------
// keyed_record_table_upsert
// Table of keyed records with lookup, delete and upsert commands. All entries
// live in one RAM; each table-bound command scans it from entry 0 upward.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  command   i_start / o_busy   i_command, i_player_key, i_team_value,
//                               i_league_value, i_slot_kind, i_today_date
//  result    o_done (strobe)    o_status, o_rec_player, o_rec_team,
//                               o_rec_league, o_rec_slot_kind,
//                               o_rec_first_date, o_rec_last_date
//
// A command that needs no table access (zero key, rejected upsert, reserved
// code) gives its word in the cycle after acceptance. Any other command scans
// the RAM one entry per cycle through its single read port and stops early
// when a matching entry turns up. After reset a clearing pass writes every
// entry invalid; o_busy stays high until it ends. The result word is held for
// one cycle only and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module keyed_record_table_upsert #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_player_key,
    input  logic [31:0] i_team_value,
    input  logic [31:0] i_league_value,
    input  logic [7:0]  i_slot_kind,
    input  logic [31:0] i_today_date,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [31:0] o_rec_player,
    output logic [31:0] o_rec_team,
    output logic [31:0] o_rec_league,
    output logic [7:0]  o_rec_slot_kind,
    output logic [31:0] o_rec_first_date,
    output logic [31:0] o_rec_last_date
);

    import krtu_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    // Control registers.
    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_issue_done, n_issue_done;
    logic          r_rd_vld, n_rd_vld;
    logic          r_hit, n_hit;
    logic          r_free_found, n_free_found;
    logic          r_done, n_done;

    // Payload registers.
    logic [IW-1:0] r_cmp_idx, n_cmp_idx;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [IW-1:0] r_free_idx, n_free_idx;
    t_entry        r_hit_data, n_hit_data;
    t_cmd          r_cmd, n_cmd;
    t_record       r_req, n_req;
    t_status       r_status, n_status;
    t_record       r_rec, n_rec;

    // RAM port signals.
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry        rd_entry;

    logic          accept;
    logic          trivial;
    t_status       trivial_status;
    logic          match;
    t_entry        upd_entry;

    krtu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);
    assign accept   = i_start && (r_state == S_IDLE);
    assign match    = r_rd_vld && rd_entry.valid && (rd_entry.rec.key == r_req.key);

    // Commands that are settled without touching the table.
    always_comb begin
        trivial        = 1'b0;
        trivial_status = STAT_IGNORED;
        case (t_cmd'(i_command))
            CMD_LOOKUP: begin
                trivial        = (i_player_key == 32'd0);
                trivial_status = STAT_NOT_FOUND;
            end
            CMD_DELETE: begin
                trivial = (i_player_key == 32'd0);
            end
            CMD_UPSERT: begin
                trivial = (i_player_key == 32'd0) || (i_team_value == 32'd0)
                          || (i_today_date == 32'd0);
            end
            default: begin
                trivial = 1'b1;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && !trivial) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (match || (r_rd_vld && r_cmp_idx == LAST_IDX)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The matched record with this upsert's fields merged in.
    always_comb begin
        upd_entry               = r_hit_data;
        upd_entry.valid         = 1'b1;
        upd_entry.rec.team      = r_req.team;
        upd_entry.rec.league    = r_req.league;
        upd_entry.rec.kind      = r_req.kind;
        upd_entry.rec.last_date = r_req.last_date;
    end

    // Outputs and datapath next values.
    always_comb begin
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_rd_vld     = 1'b0;
        n_hit        = r_hit;
        n_free_found = r_free_found;
        n_done       = 1'b0;
        n_cmp_idx    = r_idx;
        n_hit_idx    = r_hit_idx;
        n_free_idx   = r_free_idx;
        n_hit_data   = r_hit_data;
        n_cmd        = r_cmd;
        n_req        = r_req;
        n_status     = r_status;
        n_rec        = r_rec;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = '0;

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_idx  = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd            = t_cmd'(i_command);
                    n_req.key        = i_player_key;
                    n_req.team       = i_team_value;
                    n_req.league     = i_league_value;
                    n_req.kind       = i_slot_kind;
                    n_req.first_date = i_today_date;
                    n_req.last_date  = i_today_date;
                    n_idx            = '0;
                    n_issue_done     = 1'b0;
                    n_hit            = 1'b0;
                    n_free_found     = 1'b0;
                    if (trivial) begin
                        n_done   = 1'b1;
                        n_status = trivial_status;
                        n_rec    = '0;
                    end
                end
            end
            S_SCAN: begin
                // Issue side: one read per cycle until the last entry.
                n_rd_vld = !r_issue_done;
                if (!r_issue_done) begin
                    if (r_idx == LAST_IDX) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                // Compare side: data for r_cmp_idx arrives this cycle.
                if (match) begin
                    n_hit      = 1'b1;
                    n_hit_idx  = r_cmp_idx;
                    n_hit_data = rd_entry;
                end else if (r_rd_vld && !rd_entry.valid && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_cmp_idx;
                end
            end
            S_FINISH: begin
                n_done   = 1'b1;
                n_status = STAT_NOT_FOUND;
                n_rec    = '0;
                if (r_hit) begin
                    case (r_cmd)
                        CMD_LOOKUP: begin
                            n_status = STAT_FOUND;
                            n_rec    = r_hit_data.rec;
                        end
                        CMD_DELETE: begin
                            ram_we          = 1'b1;
                            ram_waddr       = r_hit_idx;
                            ram_wdata       = r_hit_data;
                            ram_wdata.valid = 1'b0;
                            n_status        = STAT_DELETED;
                            n_rec           = r_hit_data.rec;
                        end
                        CMD_UPSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_hit_idx;
                            ram_wdata = upd_entry;
                            n_status  = STAT_UPDATED;
                            n_rec     = upd_entry.rec;
                        end
                        default: begin
                            n_status = STAT_IGNORED;
                        end
                    endcase
                end else if (r_cmd == CMD_UPSERT) begin
                    if (r_free_found) begin
                        ram_we          = 1'b1;
                        ram_waddr       = r_free_idx;
                        ram_wdata.valid = 1'b1;
                        ram_wdata.rec   = r_req;
                        n_status        = STAT_CREATED;
                        n_rec           = r_req;
                    end else begin
                        n_status = STAT_FULL;
                    end
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_issue_done <= n_issue_done;
            r_rd_vld     <= n_rd_vld;
            r_hit        <= n_hit;
            r_free_found <= n_free_found;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_hit_data <= n_hit_data;
        r_cmd      <= n_cmd;
        r_req      <= n_req;
        r_status   <= n_status;
        r_rec      <= n_rec;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_rec_player     = r_rec.key;
    assign o_rec_team       = r_rec.team;
    assign o_rec_league     = r_rec.league;
    assign o_rec_slot_kind  = r_rec.kind;
    assign o_rec_first_date = r_rec.first_date;
    assign o_rec_last_date  = r_rec.last_date;

endmodule

/* hw/rtl/krtu_ram.sv */
// ----------------------------------------------------------------------------
// krtu_ram
// Generic single-clock RAM with one write port and one read port. Read data
// is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module krtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* verif/krtu_table_checker.sv */
// ----------------------------------------------------------------------------
// krtu_table_checker
// Watches the command and result channels of the keyed record table. Keeps
// its own copy of the table, works out the reply to every accepted command
// word and compares each result word against the oldest reply still owed.
// ----------------------------------------------------------------------------
module krtu_table_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_player_key,
    input  logic [31:0] i_team_value,
    input  logic [31:0] i_league_value,
    input  logic [7:0]  i_slot_kind,
    input  logic [31:0] i_today_date,
    input  logic        i_done,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_rec_player,
    input  logic [31:0] i_rec_team,
    input  logic [31:0] i_rec_league,
    input  logic [7:0]  i_rec_slot_kind,
    input  logic [31:0] i_rec_first_date,
    input  logic [31:0] i_rec_last_date,
    input  logic        i_end_check,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import krtu_pkg::*;

    typedef struct packed {
        t_status status;
        t_record rec;
    } t_table_reply;

    logic         row_valid [TABLE_DEPTH];
    t_record      row_data  [TABLE_DEPTH];
    t_table_reply owed_replies [$];
    int           fail_count = 0;
    int           reply_index = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_error(input string msg);
        $display("[%0t] result word %0d: %s", $realtime, reply_index, msg);
        fail_count++;
    endtask

    function automatic int find_row(input logic [31:0] key);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (row_valid[i] && row_data[i].key == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one command to the table copy and returns the reply it owes.
    function automatic t_table_reply apply_command(input logic [1:0] cmd,
                                                   input logic [31:0] key,
                                                   input logic [31:0] team,
                                                   input logic [31:0] league,
                                                   input logic [7:0] kind,
                                                   input logic [31:0] today);
        t_table_reply reply;
        int           hit;
        int           open_row;
        int           idx;
        reply.status = STAT_IGNORED;
        reply.rec    = '0;
        case (t_cmd'(cmd))
            CMD_LOOKUP: begin
                idx = (key != 0) ? find_row(key) : -1;
                reply.status = STAT_NOT_FOUND;
                if (idx >= 0) begin
                    reply.status = STAT_FOUND;
                    reply.rec    = row_data[idx];
                end
            end
            CMD_DELETE: begin
                if (key != 0) begin
                    idx = find_row(key);
                    reply.status = STAT_NOT_FOUND;
                    if (idx >= 0) begin
                        reply.status   = STAT_DELETED;
                        reply.rec      = row_data[idx];
                        row_valid[idx] = 1'b0;
                    end
                end
            end
            CMD_UPSERT: begin
                if (key != 0 && team != 0 && today != 0) begin
                    hit      = -1;
                    open_row = -1;
                    for (int i = 0; i < TABLE_DEPTH && hit < 0; i++) begin
                        if (row_valid[i] && row_data[i].key == key) begin
                            hit = i;
                        end else if (!row_valid[i] && open_row < 0) begin
                            open_row = i;
                        end
                    end
                    if (hit >= 0) begin
                        idx = hit;
                        reply.status = STAT_UPDATED;
                    end else if (open_row >= 0) begin
                        idx = open_row;
                        row_valid[idx]           = 1'b1;
                        row_data[idx].key        = key;
                        row_data[idx].first_date = today;
                        reply.status = STAT_CREATED;
                    end else begin
                        idx = -1;
                        reply.status = STAT_FULL;
                    end
                    if (idx >= 0) begin
                        row_data[idx].team      = team;
                        row_data[idx].league    = league;
                        row_data[idx].kind      = kind;
                        row_data[idx].last_date = today;
                        reply.rec = row_data[idx];
                    end
                end
            end
            default: reply.status = STAT_IGNORED;
        endcase
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_table_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                row_valid[i] = 1'b0;
                row_data[i]  = '0;
            end
            owed_replies.delete();
        end else begin
            // A result word leaves before a new command word is taken in.
            if (i_done) begin
                if (owed_replies.size() == 0) begin
                    report_error("result word with no command outstanding");
                end else begin
                    want = owed_replies.pop_front();
                    if (i_status !== want.status)
                        report_error($sformatf("status expected %0d got %0d",
                                               want.status, i_status));
                    if (i_rec_player !== want.rec.key)
                        report_error($sformatf("rec_player expected %h got %h",
                                               want.rec.key, i_rec_player));
                    if (i_rec_team !== want.rec.team)
                        report_error($sformatf("rec_team expected %h got %h",
                                               want.rec.team, i_rec_team));
                    if (i_rec_league !== want.rec.league)
                        report_error($sformatf("rec_league expected %h got %h",
                                               want.rec.league, i_rec_league));
                    if (i_rec_slot_kind !== want.rec.kind)
                        report_error($sformatf("rec_slot_kind expected %h got %h",
                                               want.rec.kind, i_rec_slot_kind));
                    if (i_rec_first_date !== want.rec.first_date)
                        report_error($sformatf("rec_first_date expected %h got %h",
                                               want.rec.first_date, i_rec_first_date));
                    if (i_rec_last_date !== want.rec.last_date)
                        report_error($sformatf("rec_last_date expected %h got %h",
                                               want.rec.last_date, i_rec_last_date));
                end
                reply_index++;
            end
            if (i_start && !i_busy) begin
                owed_replies.push_back(apply_command(i_command, i_player_key,
                                                     i_team_value, i_league_value,
                                                     i_slot_kind, i_today_date));
            end
            if (i_end_check) begin
                while (owed_replies.size() > 0) begin
                    want = owed_replies.pop_front();
                    report_error($sformatf("no result word for status %0d",
                                           want.status));
                end
            end
        end
        o_pending    <= owed_replies.size();
        o_fail_count <= fail_count;
    end

endmodule

/* verif/tb_keyed_record_table_upsert.sv */
// ----------------------------------------------------------------------------
// tb_keyed_record_table_upsert
// Drives lookup, delete and upsert command words into the keyed record table:
// a directed opening on the special cases, then random traffic that churns a
// few keys, fills the table past full and then frees and refills entries. A
// checker module beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_keyed_record_table_upsert;
    timeunit 1ns;
    timeprecision 1ps;

    import krtu_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int KEY_POOL     = 320;
    localparam int RANDOM_WORDS = 1030;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_command;
    logic [31:0] i_player_key;
    logic [31:0] i_team_value;
    logic [31:0] i_league_value;
    logic [7:0]  i_slot_kind;
    logic [31:0] i_today_date;
    logic        o_done;
    logic [2:0]  o_status;
    logic [31:0] o_rec_player;
    logic [31:0] o_rec_team;
    logic [31:0] o_rec_league;
    logic [7:0]  o_rec_slot_kind;
    logic [31:0] o_rec_first_date;
    logic [31:0] o_rec_last_date;
    logic        end_check;
    int          fail_count;
    int          pending;

    logic [31:0] key_pool [KEY_POOL];

    keyed_record_table_upsert #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_command        (i_command),
        .i_player_key     (i_player_key),
        .i_team_value     (i_team_value),
        .i_league_value   (i_league_value),
        .i_slot_kind      (i_slot_kind),
        .i_today_date     (i_today_date),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_rec_player     (o_rec_player),
        .o_rec_team       (o_rec_team),
        .o_rec_league     (o_rec_league),
        .o_rec_slot_kind  (o_rec_slot_kind),
        .o_rec_first_date (o_rec_first_date),
        .o_rec_last_date  (o_rec_last_date)
    );

    krtu_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) table_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_busy           (o_busy),
        .i_command        (i_command),
        .i_player_key     (i_player_key),
        .i_team_value     (i_team_value),
        .i_league_value   (i_league_value),
        .i_slot_kind      (i_slot_kind),
        .i_today_date     (i_today_date),
        .i_done           (o_done),
        .i_status         (o_status),
        .i_rec_player     (o_rec_player),
        .i_rec_team       (o_rec_team),
        .i_rec_league     (o_rec_league),
        .i_rec_slot_kind  (o_rec_slot_kind),
        .i_rec_first_date (o_rec_first_date),
        .i_rec_last_date  (o_rec_last_date),
        .i_end_check      (end_check),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Presents one command word and holds it until the block takes it.
    task automatic send_command(input t_cmd cmd, input logic [31:0] key,
                                input logic [31:0] team, input logic [31:0] league,
                                input logic [7:0] kind, input logic [31:0] today);
        @(negedge i_clk);
        i_start        <= 1'b1;
        i_command      <= cmd;
        i_player_key   <= key;
        i_team_value   <= team;
        i_league_value <= league;
        i_slot_kind    <= kind;
        i_today_date   <= today;
        do @(posedge i_clk); while (o_busy);
    endtask

    initial begin
        int          pick;
        int          noise;
        int          fill_next;
        int          gap;
        int          waited;
        t_cmd        cmd;
        logic [31:0] key;
        logic [31:0] team;
        logic [31:0] league;
        logic [7:0]  kind;
        logic [31:0] today;

        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_command      = CMD_LOOKUP;
        i_player_key   = '0;
        i_team_value   = '0;
        i_league_value = '0;
        i_slot_kind    = '0;
        i_today_date   = '0;
        end_check      = 1'b0;
        fill_next      = 0;

        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i] = $urandom();
            if (key_pool[i] == 0) key_pool[i] = i + 1;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty table, rejected words, field extremes,
        // hit and miss on every command, and reuse of a freed entry.
        send_command(CMD_LOOKUP, 32'h0, 32'h1, 32'h1, 8'h1, 32'h1);
        send_command(CMD_LOOKUP, 32'h5, 32'h0, 32'h0, 8'h0, 32'h0);
        send_command(CMD_DELETE, 32'h0, 32'h1, 32'h1, 8'h1, 32'h1);
        send_command(CMD_DELETE, 32'h5, 32'h1, 32'h1, 8'h1, 32'h1);
        send_command(CMD_UPSERT, 32'h0, 32'h7, 32'h7, 8'h7, 32'h7);
        send_command(CMD_UPSERT, 32'h9, 32'h0, 32'h7, 8'h7, 32'h7);
        send_command(CMD_UPSERT, 32'h9, 32'h7, 32'h7, 8'h7, 32'h0);
        send_command(CMD_UPSERT, 32'h0, 32'h0, 32'h0, 8'h0, 32'h0);
        send_command(CMD_UPSERT, '1, '1, 32'h0, '1, '1);
        send_command(CMD_UPSERT, 32'h1, 32'h1, '1, 8'h0, 32'h1);
        send_command(CMD_UPSERT, 32'h1, 32'h2, 32'h3, 8'h7f, 32'h2);
        send_command(CMD_LOOKUP, 32'h1, 32'h0, 32'h0, 8'h0, 32'h0);
        send_command(CMD_LOOKUP, '1, '1, '1, '1, '1);
        send_command(CMD_DELETE, '1, 32'h0, 32'h0, 8'h0, 32'h0);
        send_command(CMD_LOOKUP, '1, 32'h0, 32'h0, 8'h0, 32'h0);
        send_command(CMD_DELETE, '1, 32'h0, 32'h0, 8'h0, 32'h0);
        send_command(CMD_UPSERT, 32'h2, 32'h12, 32'h34, 8'h56, 32'h78);
        send_command(CMD_RSVD, '1, '1, '1, '1, '1);
        send_command(CMD_RSVD, 32'h0, 32'h0, 32'h0, 8'h0, 32'h0);
        send_command(CMD_DELETE, 32'h1, 32'h0, 32'h0, 8'h0, 32'h0);
        send_command(CMD_LOOKUP, 32'h2, 32'h0, 32'h0, 8'h0, 32'h0);
        send_command(CMD_UPSERT, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 8'h55,
                     32'h55555555);

        // Random traffic in three stretches: churn on a few keys, a fill
        // that runs the table past full, then a mix that frees and refills.
        for (int r = 0; r < RANDOM_WORDS; r++) begin
            pick   = $urandom_range(0, 99);
            team   = $urandom();
            league = $urandom();
            kind   = 8'($urandom());
            today  = $urandom();
            if (team == 0) team = 1;
            if (today == 0) today = 1;
            if (r < 300) begin
                cmd = (pick < 30) ? CMD_LOOKUP : (pick < 50) ? CMD_DELETE : CMD_UPSERT;
                key = key_pool[$urandom_range(0, 39)];
            end else if (r < 650) begin
                cmd = (pick < 10) ? CMD_LOOKUP : (pick < 15) ? CMD_DELETE : CMD_UPSERT;
                if (cmd == CMD_UPSERT) begin
                    key = key_pool[fill_next];
                    fill_next = (fill_next + 1) % KEY_POOL;
                end else begin
                    key = key_pool[$urandom_range(0, KEY_POOL - 1)];
                end
            end else begin
                cmd = (pick < 35) ? CMD_LOOKUP : (pick < 70) ? CMD_DELETE : CMD_UPSERT;
                key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            end
            noise = $urandom_range(0, 99);
            if (noise < 3) cmd = CMD_RSVD;
            else if (noise < 6) key = '0;
            else if (noise < 8) team = '0;
            else if (noise < 10) today = '0;
            else if (noise < 13) key = $urandom();
            send_command(cmd, key, team, league, kind, today);

            // No idling at all through the middle of the fill stretch.
            if ((r < 450 || r >= 650) && $urandom_range(0, 99) < 19) begin
                gap = $urandom_range(1, 6);
                repeat (gap) begin
                    @(negedge i_clk);
                    i_start        <= 1'b0;
                    i_player_key   <= $urandom();
                    i_team_value   <= $urandom();
                    i_today_date   <= $urandom();
                end
            end
        end
        @(negedge i_clk);
        i_start <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 4 * (TABLE_DEPTH + 8)) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        @(negedge i_clk);
        end_check <= 1'b1;
        @(negedge i_clk);
        end_check <= 1'b0;

        if (fail_count == 0) begin
            $display("tb_keyed_record_table_upsert passed");
        end else begin
            $display("tb_keyed_record_table_upsert failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_keyed_record_table_upsert failed");
        $finish;
    end

endmodule
